@@ design/cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cmbe_pkg
// Shared types and constants of the combination enumerator: field widths,
// configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cmbe_pkg;

  localparam int LEN_W   = 5;
  localparam int POS_W   = 4;
  localparam int BASE_W  = 8;
  localparam int VAL_W   = 9;
  localparam int CFG_A_W = 1;

  localparam logic [CFG_A_W-1:0] CFG_POOL_SIZE  = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_INDEX_BASE = 1'b1;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [LEN_W-1:0] POOL_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FILL,
    ST_EMIT_RD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ design/cmbe_store.sv @@
// ----------------------------------------------------------------------------
// cmbe_store
// Index store of the current combination: one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbe_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/combination_enumerator.sv @@
// ----------------------------------------------------------------------------
// combination_enumerator
// Lexicographic k-combination generator over a pool of up to MAX_POOL items.
// Restart of length k: k index writes (FILL), then a store read (EMIT_RD)
//   before the first word, then one word per cycle while out_stall is low.
// Advance: a store read (SCAN) and a compare (CHECK) per scanned index, then
//   the refill writes, one per cycle, a store read and the words as above.
// One item at a time; in_stall stays high until its last word is taken.
// Reset: length 0, not exhausted, pool_size 16, index_base 0.
// ----------------------------------------------------------------------------
`default_nettype none

module combination_enumerator #(
  parameter int MAX_POOL = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [cmbe_pkg::LEN_W-1:0]    in_start_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_valid_res,
  output logic      [cmbe_pkg::LEN_W-1:0]    out_comb_length,
  output logic      [cmbe_pkg::POS_W-1:0]    out_position,
  output logic      [cmbe_pkg::VAL_W-1:0]    out_index_value,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cmbe_pkg::CFG_A_W-1:0]  cfg_index,
  input  wire logic [cmbe_pkg::BASE_W-1:0]   cfg_data
);

  localparam int IDX_W    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int POOL_CAP = (MAX_POOL > 31) ? 31 : MAX_POOL;
  localparam int LW       = cmbe_pkg::LEN_W;

  cmbe_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]                 pool_size_r;
  logic [cmbe_pkg::BASE_W-1:0]   index_base_r;
  logic [LW-1:0]                 len_r, len_nxt;
  logic                          exhausted_r, exhausted_nxt;
  logic                          ok_r, ok_nxt;
  logic [LW-1:0]                 pos_r, pos_nxt;
  logic [LW-1:0]                 scan_r, scan_nxt;
  logic [IDX_W-1:0]              fill_v_r, fill_v_nxt;

  logic [LW-1:0]    eff_pool;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] rdata;
  logic             in_fire;
  logic             out_fire;
  logic             below_max;

  assign eff_pool  = (pool_size_r > LW'(POOL_CAP)) ? LW'(POOL_CAP) : pool_size_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign below_max = (6'(rdata) + 6'(len_r)) < (6'(scan_r) + 6'(eff_pool));
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r  <= cmbe_pkg::POOL_RESET;
      index_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmbe_pkg::CFG_POOL_SIZE:  pool_size_r  <= cfg_data[LW-1:0];
        cmbe_pkg::CFG_INDEX_BASE: index_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmbe_store #(
    .DEPTH (MAX_POOL),
    .AW    (IDX_W),
    .DW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (fill_v_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmbe_pkg::ST_IDLE;
      len_r       <= '0;
      exhausted_r <= 1'b0;
      ok_r        <= 1'b0;
      pos_r       <= '0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      exhausted_r <= exhausted_nxt;
      ok_r        <= ok_nxt;
      pos_r       <= pos_nxt;
      scan_r      <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_v_r <= fill_v_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    exhausted_nxt = exhausted_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    scan_nxt      = scan_r;
    fill_v_nxt    = fill_v_r;
    we            = 1'b0;
    waddr         = IDX_W'(scan_r);
    raddr         = IDX_W'(pos_r);
    in_stall      = 1'b1;
    out_valid     = 1'b0;

    case (state_r)
      cmbe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_fire) begin
          pos_nxt = '0;
          if (in_op == cmbe_pkg::OP_RESTART) begin
            if (in_start_length > eff_pool) begin
              len_nxt       = '0;
              exhausted_nxt = 1'b1;
              ok_nxt        = 1'b0;
              state_nxt     = cmbe_pkg::ST_OUT;
            end else begin
              len_nxt       = in_start_length;
              exhausted_nxt = 1'b0;
              ok_nxt        = 1'b1;
              scan_nxt      = '0;
              fill_v_nxt    = '0;
              state_nxt     = (in_start_length == '0) ? cmbe_pkg::ST_OUT
                                                      : cmbe_pkg::ST_FILL;
            end
          end else if (exhausted_r) begin
            ok_nxt    = 1'b0;
            state_nxt = cmbe_pkg::ST_OUT;
          end else if (len_r != '0) begin
            scan_nxt  = len_r - LW'(1);
            state_nxt = cmbe_pkg::ST_SCAN;
          end else if (eff_pool == '0) begin
            exhausted_nxt = 1'b1;
            ok_nxt        = 1'b0;
            state_nxt     = cmbe_pkg::ST_OUT;
          end else begin
            // grow from the empty combination to length one
            len_nxt    = LW'(1);
            ok_nxt     = 1'b1;
            scan_nxt   = '0;
            fill_v_nxt = '0;
            state_nxt  = cmbe_pkg::ST_FILL;
          end
        end
      end

      cmbe_pkg::ST_SCAN: begin
        raddr     = IDX_W'(scan_r);
        state_nxt = cmbe_pkg::ST_CHECK;
      end

      cmbe_pkg::ST_CHECK: begin
        if (below_max) begin
          ok_nxt     = 1'b1;
          fill_v_nxt = IDX_W'(rdata + IDX_W'(1));
          state_nxt  = cmbe_pkg::ST_FILL;
        end else if (scan_r != '0) begin
          scan_nxt  = scan_r - LW'(1);
          state_nxt = cmbe_pkg::ST_SCAN;
        end else if (len_r >= eff_pool) begin
          len_nxt       = '0;
          exhausted_nxt = 1'b1;
          ok_nxt        = 1'b0;
          state_nxt     = cmbe_pkg::ST_OUT;
        end else begin
          // step to the next length, starting at 0..k
          len_nxt    = len_r + LW'(1);
          ok_nxt     = 1'b1;
          scan_nxt   = '0;
          fill_v_nxt = '0;
          state_nxt  = cmbe_pkg::ST_FILL;
        end
      end

      cmbe_pkg::ST_FILL: begin
        we    = 1'b1;
        waddr = IDX_W'(scan_r);
        if (scan_r == len_r - LW'(1)) begin
          pos_nxt   = '0;
          state_nxt = cmbe_pkg::ST_EMIT_RD;
        end else begin
          scan_nxt   = scan_r + LW'(1);
          fill_v_nxt = fill_v_r + IDX_W'(1);
        end
      end

      cmbe_pkg::ST_EMIT_RD: begin
        raddr     = IDX_W'(pos_r);
        state_nxt = cmbe_pkg::ST_OUT;
      end

      cmbe_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          raddr = IDX_W'(LW'(pos_r + LW'(1)));
          if (out_last) begin
            state_nxt = cmbe_pkg::ST_IDLE;
          end else begin
            pos_nxt = pos_r + LW'(1);
          end
        end else begin
          raddr = IDX_W'(pos_r);
        end
      end

      default: begin
        state_nxt = cmbe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_res   = ok_r;
  assign out_comb_length = len_r;
  assign out_position    = pos_r[cmbe_pkg::POS_W-1:0];
  assign out_index_value = (len_r == '0) ? '0
                         : cmbe_pkg::VAL_W'(rdata) + cmbe_pkg::VAL_W'(index_base_r);
  assign out_last        = (len_r == '0) || (pos_r == len_r - LW'(1));

  a_out_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a word is pending");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input accepted back to back");

  a_exh_empty : assert property (@(posedge clk) disable iff (!rst_n)
    exhausted_r |-> (len_r == '0))
    else $error("exhausted with nonzero length");

  a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cmbe_pkg::ST_FILL) |-> (scan_r < len_r))
    else $error("fill beyond current length");

  a_reject_shape : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_last && (out_comb_length == '0)))
    else $error("rejected word malformed");

endmodule

`default_nettype wire
